// ===== hw/rtl/wsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pkg: shared definitions of the wildcard star pattern matcher
// sizes of the element store and position vector, byte and command codes,
// and the word passed from the front queue to the back engine
// ----------------------------------------------------------------------------
package wsm_pkg;

	localparam int MAX_PAT = 32;
	localparam int POS_W   = MAX_PAT + 1;
	localparam int LEN_W   = $clog2(MAX_PAT + 1);
	localparam int IDX_W   = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;

	localparam logic [7:0] DOT_BYTE  = 8'h2E;
	localparam logic [7:0] STAR_BYTE = 8'h2A;

	localparam logic [1:0] CMD_PATTERN = 2'd0;
	localparam logic [1:0] CMD_TEXT    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_STAR    = 2'd1;
	localparam logic [1:0] KIND_TEXT    = 2'd2;
	localparam logic [1:0] KIND_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       first;
		logic       is_dot;
	} op_t;

endpackage

// ===== hw/rtl/wsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_front: input classifier and operation queue
// sorts each accepted word into pattern element, star, text byte or restart,
// drops unused commands and holds up to two operations for the back engine
// ----------------------------------------------------------------------------
module wsm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      command,
	input  logic [7:0]      byte_value,
	input  logic            first,
	output logic            op_valid,
	output wsm_pkg::op_t    op,
	input  logic            op_pop
);

	wsm_pkg::op_t op_in;
	logic         keep;
	logic         push;
	wsm_pkg::op_t buf_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	always_comb begin
		op_in.value  = byte_value;
		op_in.first  = 1'b0;
		op_in.is_dot = (byte_value == wsm_pkg::DOT_BYTE);
		op_in.kind   = wsm_pkg::KIND_TEXT;
		keep         = 1'b1;
		case (command)
			wsm_pkg::CMD_PATTERN: begin
				op_in.first = first;
				op_in.kind  = (byte_value == wsm_pkg::STAR_BYTE) ?
					wsm_pkg::KIND_STAR : wsm_pkg::KIND_CHAR;
			end
			wsm_pkg::CMD_TEXT: begin
				op_in.kind = wsm_pkg::KIND_TEXT;
			end
			wsm_pkg::CMD_RESTART: begin
				op_in.kind = wsm_pkg::KIND_RESTART;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall && keep;
	assign op_valid = (count_q != 2'd0);
	assign op       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, op_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> op_valid)
		else $error("queue popped while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree while empty");

endmodule

// ===== hw/rtl/wsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_back: element store and bit-parallel position vector
// keeps the pattern elements, steps the closed position vector one text byte per cycle
// while not held by out_stall, and registers the match result toward the output channel
// ----------------------------------------------------------------------------
module wsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  wsm_pkg::op_t    op,
	output logic            op_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            match,
	output logic            overflow
);

	logic [7:0]                 chars_q [wsm_pkg::MAX_PAT];
	logic [wsm_pkg::MAX_PAT-1:0] wild_q;
	logic [wsm_pkg::MAX_PAT-1:0] star_q;
	logic [wsm_pkg::LEN_W-1:0]  len_q;
	logic                       ovf_q;
	// closure of the empty text, kept up to date as elements arrive
	logic [wsm_pkg::POS_W-1:0]  init_q;
	// active positions, always stored with the star closure applied
	logic [wsm_pkg::POS_W-1:0]  active_q;
	logic                       out_valid_q;
	logic                       match_q;
	logic                       overflow_q;

	logic                       is_pattern;
	logic                       gives_result;
	logic                       pop_text;
	logic                       pop_restart;
	logic                       pop_pattern;
	logic [wsm_pkg::LEN_W-1:0]  base_len;
	logic [wsm_pkg::LEN_W-1:0]  new_len;
	logic                       base_ovf;
	logic                       new_ovf;
	logic [wsm_pkg::POS_W-1:0]  base_init;
	logic [wsm_pkg::POS_W-1:0]  new_init;
	logic [wsm_pkg::IDX_W-1:0]  wr_idx;
	logic [wsm_pkg::IDX_W-1:0]  star_idx;
	logic                       wr_char;
	logic                       wr_star;

	logic [wsm_pkg::MAX_PAT-1:0] live;
	logic [wsm_pkg::MAX_PAT-1:0] hit;
	logic [wsm_pkg::POS_W-1:0]  nxt;
	logic [wsm_pkg::POS_W-1:0]  prop;
	logic [wsm_pkg::POS_W-1:0]  gen;
	logic [wsm_pkg::POS_W-1:0]  sum;
	logic [wsm_pkg::POS_W-1:0]  closed;

	assign is_pattern   = (op.kind == wsm_pkg::KIND_CHAR) || (op.kind == wsm_pkg::KIND_STAR);
	assign gives_result = !is_pattern;
	assign op_pop       = op_valid && (is_pattern || !out_valid_q || !out_stall);
	assign pop_pattern  = op_pop && is_pattern;
	assign pop_text     = op_pop && (op.kind == wsm_pkg::KIND_TEXT);
	assign pop_restart  = op_pop && (op.kind == wsm_pkg::KIND_RESTART);

	// pattern element update
	always_comb begin
		base_len  = op.first ? '0 : len_q;
		base_ovf  = op.first ? 1'b0 : ovf_q;
		base_init = op.first ? wsm_pkg::POS_W'(1) : init_q;
		new_len   = base_len;
		new_ovf   = base_ovf;
		new_init  = base_init;
		wr_idx    = base_len[wsm_pkg::IDX_W-1:0];
		star_idx  = wsm_pkg::IDX_W'(base_len - wsm_pkg::LEN_W'(1));
		wr_char   = 1'b0;
		wr_star   = 1'b0;
		if (op.kind == wsm_pkg::KIND_CHAR) begin
			if (base_len < wsm_pkg::LEN_W'(wsm_pkg::MAX_PAT)) begin
				wr_char           = 1'b1;
				new_len           = base_len + wsm_pkg::LEN_W'(1);
				new_init[new_len] = 1'b0;
			end else begin
				new_ovf = 1'b1;
			end
		end else if (op.kind == wsm_pkg::KIND_STAR) begin
			if (base_len != '0) begin
				wr_star            = 1'b1;
				new_init[base_len] = base_init[base_len] |
					base_init[base_len - wsm_pkg::LEN_W'(1)];
			end
		end
	end

	// text step: literal or wildcard hits, then closure over starred elements
	always_comb begin
		for (int i = 0; i < wsm_pkg::MAX_PAT; i++) begin
			live[i] = (wsm_pkg::LEN_W'(i) < len_q);
			hit[i]  = active_q[i] && live[i] && (wild_q[i] || (chars_q[i] == op.value));
		end
		nxt  = {1'b0, hit & star_q} | {hit & ~star_q, 1'b0};
		// carry chain: a starred element passes its position on to the next one
		prop = {1'b0, star_q & live};
		gen  = prop & nxt;
		sum  = prop + gen;
		closed = nxt | (sum ^ prop ^ gen);
	end

	always_ff @(posedge clk) begin
		if (pop_pattern && wr_char) begin
			chars_q[wr_idx] <= op.value;
			wild_q[wr_idx]  <= op.is_dot;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_pattern && wr_char) begin
			star_q[wr_idx] <= 1'b0;
		end else if (pop_pattern && wr_star) begin
			star_q[star_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			init_q   <= wsm_pkg::POS_W'(1);
			active_q <= wsm_pkg::POS_W'(1);
		end else if (pop_pattern) begin
			len_q    <= new_len;
			ovf_q    <= new_ovf;
			init_q   <= new_init;
			active_q <= new_init;
		end else if (pop_restart) begin
			active_q <= init_q;
		end else if (pop_text) begin
			active_q <= closed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop && gives_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_restart) begin
			match_q    <= init_q[len_q] && !ovf_q;
			overflow_q <= ovf_q;
		end else if (pop_text) begin
			match_q    <= closed[len_q] && !ovf_q;
			overflow_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign match     = match_q;
	assign overflow  = overflow_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(match_q && overflow_q))
		else $error("match reported while pattern overflowed");

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= wsm_pkg::LEN_W'(wsm_pkg::MAX_PAT))
		else $error("pattern length beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		init_q[0])
		else $error("empty text lost position zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop_pattern |=> (active_q == init_q))
		else $error("pattern load did not reset text positions");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && op_pop) |-> is_pattern)
		else $error("result popped while output held");

endmodule

// ===== hw/rtl/wildcard_star_pattern_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_star_pattern_matcher_top: whole-string '.' and '*' pattern matcher
// pattern bytes load elements, text bytes step an NFA, one result per text
// byte or restart
// ----------------------------------------------------------------------------
// usage
// - input words (command, byte_value, first) are taken when in_valid is high
//   and in_stall is low; command 0 loads a pattern byte ('.' any byte, '*'
//   repeats the element before it), first on a pattern byte starts a new one
// - command 1 steps one text byte, command 2 restarts the text; each gives
//   one output word (match, overflow), command 0 and 3 give none
// - the output word is registered at the edge that takes the word out of
//   the two-entry front queue
// - throughput: one word per cycle unless out_stall holds the output; the position
//   vector is updated by one compare row and one carry chain per cycle in the back engine
// - out_stall holds the output word; the queue keeps taking words until it
//   holds two, then in_stall rises
// - reset empties the queue, clears the pattern length and overflow flag and
//   sets the text to empty; element storage is left as is
// ----------------------------------------------------------------------------
module wildcard_star_pattern_matcher_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] byte_value,
	input  logic       first,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       match,
	output logic       overflow
);

	logic         op_valid;
	logic         op_pop;
	wsm_pkg::op_t op;

	wsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.byte_value (byte_value),
		.first      (first),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop)
	);

	wsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.match     (match),
		.overflow  (overflow)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wildcard star pattern matcher
// streams pattern loads, text restarts and text bytes into the block with
// random idling on both sides, steps a bit-vector nfa of its own for every
// accepted word and compares each output word with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 35;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] value;
		logic       first;
	} in_word_t;

	typedef struct packed {
		logic match;
		logic overflow;
	} match_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = wsm_pkg::CMD_PATTERN;
	logic [7:0] byte_value = 8'h00;
	logic       first = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       match;
	logic       overflow;

	wildcard_star_pattern_matcher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.byte_value(byte_value),
		.first(first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match(match),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_word_t    pending_words[$];
	match_word_t expected_results[$];
	in_word_t    offered_word;
	int          cyc = 0;
	int          err_cnt = 0;
	int          res_cnt = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// no idling on either side inside this window
	wire quiet = (cyc >= 1500) && (cyc < 2300);

	// nfa copy: element store, length, position vector kept before closure
	logic [7:0]                elem_char [wsm_pkg::MAX_PAT];
	bit                        elem_wild [wsm_pkg::MAX_PAT];
	bit                        elem_star [wsm_pkg::MAX_PAT];
	int                        pat_len = 0;
	logic [wsm_pkg::POS_W-1:0] positions = wsm_pkg::POS_W'(1);
	bit                        ovf_flag = 1'b0;

	function automatic logic [wsm_pkg::POS_W-1:0] close_positions(
		logic [wsm_pkg::POS_W-1:0] v);
		for (int i = 0; i < pat_len; i++)
			if (v[i] && elem_star[i])
				v[i+1] = 1'b1;
		return v;
	endfunction

	function automatic match_word_t match_status();
		logic [wsm_pkg::POS_W-1:0] v;
		match_word_t r;
		v = close_positions(positions);
		r.match = v[pat_len] && !ovf_flag;
		r.overflow = ovf_flag;
		return r;
	endfunction

	task automatic step_matcher(in_word_t w);
		logic [wsm_pkg::POS_W-1:0] cur;
		logic [wsm_pkg::POS_W-1:0] nxt;
		case (w.cmd)
			wsm_pkg::CMD_PATTERN: begin
				if (w.first) begin
					pat_len = 0;
					ovf_flag = 1'b0;
				end
				if (w.value == wsm_pkg::STAR_BYTE) begin
					// a star with nothing before it is dropped
					if (pat_len > 0)
						elem_star[pat_len-1] = 1'b1;
				end else if (pat_len < wsm_pkg::MAX_PAT) begin
					elem_char[pat_len] = w.value;
					elem_wild[pat_len] = (w.value == wsm_pkg::DOT_BYTE);
					elem_star[pat_len] = 1'b0;
					pat_len++;
				end else begin
					ovf_flag = 1'b1;
				end
				positions = wsm_pkg::POS_W'(1);
			end
			wsm_pkg::CMD_RESTART: begin
				positions = wsm_pkg::POS_W'(1);
				expected_results.push_back(match_status());
			end
			wsm_pkg::CMD_TEXT: begin
				cur = close_positions(positions);
				nxt = '0;
				for (int i = 0; i < pat_len; i++)
					if (cur[i] && (elem_wild[i] || elem_char[i] == w.value)) begin
						if (elem_star[i])
							nxt[i] = 1'b1;
						else
							nxt[i+1] = 1'b1;
					end
				positions = nxt;
				expected_results.push_back(match_status());
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_word(logic [1:0] c, logic [7:0] v, logic f);
		in_word_t w;
		w.cmd = c;
		w.value = v;
		w.first = f;
		pending_words.push_back(w);
	endtask

	function automatic logic [7:0] small_alpha();
		return 8'h61 + 8'($urandom_range(2));
	endfunction

	// random pattern, then one or more texts built to walk it, some of them mangled
	task automatic add_sequence();
		int n;
		int reps;
		int k;
		bit lead_star;
		bit rep;
		logic [7:0] b;
		logic [7:0] ch[$];
		bit st[$];
		logic [7:0] txt[$];
		n = ($urandom_range(99) < 6) ? $urandom_range(30, 40) : $urandom_range(1, 6);
		lead_star = ($urandom_range(9) == 0);
		if (lead_star)
			add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b1);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(9);
			if (k < 6)
				b = small_alpha();
			else if (k < 8)
				b = wsm_pkg::DOT_BYTE;
			else
				b = 8'($urandom_range(255));
			if (b == wsm_pkg::STAR_BYTE)
				b = wsm_pkg::DOT_BYTE;
			add_word(wsm_pkg::CMD_PATTERN, b, (i == 0) && !lead_star);
			rep = ($urandom_range(99) < 30);
			if (rep) begin
				add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
				if ($urandom_range(9) == 0)
					add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
			end
			ch.push_back(b);
			st.push_back(rep);
		end
		repeat ($urandom_range(1, 3)) begin
			add_word(wsm_pkg::CMD_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
			txt.delete();
			for (int i = 0; i < ch.size(); i++) begin
				reps = st[i] ? $urandom_range(0, 3) : 1;
				repeat (reps) begin
					if (ch[i] != wsm_pkg::DOT_BYTE)
						txt.push_back(ch[i]);
					else if ($urandom_range(3) == 0)
						txt.push_back(8'($urandom_range(255)));
					else
						txt.push_back(small_alpha());
				end
			end
			if (txt.size() > 0 && $urandom_range(3) == 0) begin
				k = $urandom_range(txt.size() - 1);
				if ($urandom_range(1) == 0)
					txt[k] = small_alpha();
				else
					txt.delete(k);
			end
			if ($urandom_range(5) == 0)
				txt.push_back(small_alpha());
			foreach (txt[i])
				add_word(wsm_pkg::CMD_TEXT, txt[i], 1'($urandom_range(1)));
		end
	endtask

	initial begin
		// empty pattern: empty text matches, one byte does not
		add_word(wsm_pkg::CMD_RESTART, 8'h00, 1'b0);
		add_word(wsm_pkg::CMD_TEXT, 8'h00, 1'b0);
		// star with no element and .**, a lone 0xff, then .** 0xff
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b1);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::DOT_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_PATTERN, 8'hFF, 1'b1);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::DOT_BYTE, 1'b1);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_PATTERN, wsm_pkg::STAR_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_PATTERN, 8'hFF, 1'b0);
		add_word(wsm_pkg::CMD_RESTART, 8'hFF, 1'b1);
		add_word(wsm_pkg::CMD_TEXT, 8'hFF, 1'b1);
		add_word(wsm_pkg::CMD_TEXT, 8'h00, 1'b0);
		add_word(wsm_pkg::CMD_TEXT, 8'hFF, 1'b0);
		// text dot and star are plain bytes
		add_word(wsm_pkg::CMD_PATTERN, 8'h61, 1'b1);
		add_word(wsm_pkg::CMD_RESTART, 8'h00, 1'b0);
		add_word(wsm_pkg::CMD_TEXT, wsm_pkg::DOT_BYTE, 1'b0);
		add_word(wsm_pkg::CMD_RESTART, 8'h00, 1'b0);
		add_word(wsm_pkg::CMD_TEXT, wsm_pkg::STAR_BYTE, 1'b0);
		add_word(CMD_UNUSED, 8'hFF, 1'b1);
		add_word(wsm_pkg::CMD_RESTART, 8'h00, 1'b0);
		add_word(wsm_pkg::CMD_TEXT, 8'h61, 1'b0);
		while (pending_words.size() < 1820) begin
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 4))
					add_word(2'($urandom_range(3)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
			end else begin
				add_sequence();
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// driver: hold the word until taken, idle at random between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				step_matcher(offered_word);
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 &&
					(quiet || $urandom_range(99) >= IDLE_PCT)) begin
					offered_word = pending_words.pop_front();
					in_valid <= 1'b1;
					command <= offered_word.cmd;
					byte_value <= offered_word.value;
					first <= offered_word.first;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each taken output word, stall at random, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		match_word_t exp_word;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				res_cnt++;
				if (expected_results.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected output word: match=%0b overflow=%0b",
							match, overflow);
				end else begin
					exp_word = expected_results.pop_front();
					if (match !== exp_word.match || overflow !== exp_word.overflow) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"mismatch at word %0d: expected match=%0b ",
								"overflow=%0b, got match=%0b overflow=%0b"},
								res_cnt, exp_word.match, exp_word.overflow,
								match, overflow);
					end
				end
			end
			if (res_cnt == 200 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
